FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent this cycle implies consequent on the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lis_pkg.sv
package lis_pkg;

  localparam int MAX_LEN = 1024;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int WORD_W  = VALUE_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } lis_state_t;

endpackage

FILE: src/lis_ram.sv
module lis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lis_length_table_unit.sv
// Longest strictly increasing subsequence unit. Each input word carries one signed value
// and an end-of-sequence flag; each output word gives the subsequence length ending at
// that value, the running best of the sequence, a copy of the end flag and an overflow
// flag. Values and their lengths live in one single-port-read memory of MAX_LEN words;
// an item is handled one at a time: a scan reads every earlier stored entry once, one
// memory read per cycle, then the result is loaded; an item dropped for capacity skips
// the scan. The finished result sits in an output register, so the next word is taken
// while it waits. Once MAX_LEN elements are held, further elements are dropped with
// overflow set and an ending length of 0. The end flag clears the count and the best
// after its result. No clearing pass follows reset.
module lis_length_table_unit
  import lis_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      end_of_sequence,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LEN_W-1:0]          ending_length,
  output logic [LEN_W-1:0]          best_length,
  output logic                      sequence_done,
  output logic                      overflow
);

`include "assert_macros.svh"

  // sequencer state
  lis_state_t state, state_next;

  // per-sequence state
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] running_best;

  // the word under work
  logic signed [VALUE_W-1:0] item_value;
  logic                      item_last;
  logic                      item_ovf;

  // scan bookkeeping
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] best_prev;
  logic             rd_pending;

  // memory port
  logic                      rd_en;
  logic                      wr_en;
  logic [WORD_W-1:0]         rd_word;
  logic signed [VALUE_W-1:0] rd_value;
  logic [CNT_W-1:0]          rd_len;

  // datapath
  logic             hit;
  logic [CNT_W-1:0] prev_final;
  logic [CNT_W-1:0] ending;
  logic [CNT_W-1:0] best_new;
  logic             load;

  // one word per entry: value in the upper bits, its ending length below
  lis_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (element_count[ADDR_W-1:0]),
    .wdata ({item_value, ending}),
    .re    (rd_en),
    .raddr (scan_idx[ADDR_W-1:0]),
    .rdata (rd_word)
  );

  assign rd_value = rd_word[WORD_W-1:CNT_W];
  assign rd_len   = rd_word[CNT_W-1:0];

  // fold in the entry read last cycle: strictly smaller value with a longer run
  assign hit        = rd_pending && (rd_value < item_value) && (rd_len > best_prev);
  assign prev_final = hit ? rd_len : best_prev;
  assign ending     = prev_final + CNT_W'(1);
  assign best_new   = (ending > running_best) ? ending : running_best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // full table: skip the scan and report overflow
          state_next = (element_count >= CNT_MAX) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx != element_count) begin
          rd_en = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          wr_en      = !item_ovf;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      running_best  <= '0;
      out_valid     <= 1'b0;
      rd_pending    <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (item_last) begin
          element_count <= '0;
          running_best  <= '0;
        end else if (!item_ovf) begin
          element_count <= element_count + CNT_W'(1);
          running_best  <= best_new;
        end
      end
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_value <= value;
      item_last  <= end_of_sequence;
      item_ovf   <= (element_count >= CNT_MAX);
      scan_idx   <= '0;
      best_prev  <= '0;
    end else begin
      if (rd_en) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      best_prev <= prev_final;
    end
    if (load) begin
      ending_length <= item_ovf ? '0 : LEN_W'(ending);
      best_length   <= item_ovf ? LEN_W'(running_best) : LEN_W'(best_new);
      sequence_done <= item_last;
      overflow      <= item_ovf;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, element_count <= CNT_MAX, "element count past capacity")
  `ASSERT_NEXT(a_end_clears, clk, rst, load && item_last, element_count == '0 && running_best == '0, "end flag did not clear sequence state")
  `ASSERT_ALWAYS(a_ovf_zero, clk, rst, !(out_valid && overflow) || ending_length == '0, "dropped word reports a length")
  `ASSERT_ALWAYS(a_best_covers, clk, rst, !(out_valid && !overflow) || (ending_length != '0 && best_length >= ending_length), "best length below ending length")

endmodule

FILE: sim/tb.sv
module tb;
  import lis_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      eos;
    bit                        hold;  // wait for every outstanding result first
  } seq_word_t;

  typedef struct {
    logic [LEN_W-1:0] ending;
    logic [LEN_W-1:0] best;
    logic             done;
    logic             ovf;
  } lis_result_t;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = MAX_LEN + 80;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      end_of_sequence = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [LEN_W-1:0]          ending_length;
  logic [LEN_W-1:0]          best_length;
  logic                      sequence_done;
  logic                      overflow;

  seq_word_t   pending_words[$];
  lis_result_t expected_lengths[$];

  // shadow of the block: stored values, their lengths, count and best
  logic signed [VALUE_W-1:0] stored_values[MAX_LEN];
  logic [LEN_W-1:0]          stored_lengths[MAX_LEN];
  int                        held_count = 0;
  logic [LEN_W-1:0]          best_so_far = '0;

  int send_idle_pct = 34;
  int recv_idle_pct = 88;
  int error_count = 0;
  int quiet_cycles = 0;
  int words_added = 0;

  lis_length_table_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value           (value),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ending_length   (ending_length),
    .best_length     (best_length),
    .sequence_done   (sequence_done),
    .overflow        (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // length of the longest strictly increasing run ending at v, then update the shadow
  function automatic lis_result_t predict_lengths(input logic signed [VALUE_W-1:0] v,
                                                  input logic eos);
    lis_result_t r;
    logic [LEN_W-1:0] best_prev;
    r.ovf    = 1'b0;
    r.ending = '0;
    if (held_count >= MAX_LEN) begin
      r.ovf = 1'b1;
    end else begin
      best_prev = '0;
      for (int j = 0; j < held_count; j++) begin
        if (stored_values[j] < v && stored_lengths[j] > best_prev)
          best_prev = stored_lengths[j];
      end
      r.ending = best_prev + 1'b1;
      stored_values[held_count]  = v;
      stored_lengths[held_count] = r.ending;
      held_count++;
      if (r.ending > best_so_far)
        best_so_far = r.ending;
    end
    r.best = best_so_far;
    r.done = eos;
    if (eos) begin
      held_count  = 0;
      best_so_far = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("tb: mismatch on %s: got %0d, want %0d (at %0t)", field, got, want, $realtime);
    error_count++;
  endtask

  // driver: a word stays on the port until taken, the next one is chosen at the same edge
  always @(posedge clk) begin
    seq_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        expected_lengths.push_back(predict_lengths(value, end_of_sequence));
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_words[0].hold && expected_lengths.size() != 0)) begin
        w = pending_words.pop_front();
        value           <= w.value;
        end_of_sequence <= w.eos;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure and result checking
  always @(posedge clk) begin
    lis_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_lengths.size() == 0) begin
          $display("tb: result word with nothing expected (at %0t)", $realtime);
          error_count++;
        end else begin
          want = expected_lengths.pop_front();
          if (ending_length !== want.ending)
            report_mismatch("ending_length", ending_length, want.ending);
          if (best_length !== want.best)
            report_mismatch("best_length", best_length, want.best);
          if (sequence_done !== want.done)
            report_mismatch("sequence_done", sequence_done, want.done);
          if (overflow !== want.ovf)
            report_mismatch("overflow", overflow, want.ovf);
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic add_word(input logic signed [VALUE_W-1:0] v, input logic eos,
                          input bit hold = 1'b0);
    seq_word_t w;
    w.value = v;
    w.eos   = eos;
    w.hold  = hold;
    pending_words.push_back(w);
    words_added++;
  endtask

  task automatic add_random_sequence(input bit hold_first);
    int len;
    int style;
    logic signed [VALUE_W-1:0] v;
    len   = $urandom_range(24, 1);
    style = $urandom_range(3);
    v     = $urandom;
    for (int k = 0; k < len; k++) begin
      case (style)
        0: v = $urandom;
        1: v = int'($urandom_range(16)) - 8;  // narrow range, plenty of equal values
        2: v = v + int'($urandom_range(6)) - 1;  // mostly rising
        default: begin
          case ($urandom_range(4))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = '0;
            3: v = -1;
            default: v = $urandom;
          endcase
        end
      endcase
      add_word(v, k == len - 1, hold_first && k == 0);
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_lengths.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // extremes, equal values and a drop back to -1
    add_word(32'sh8000_0000, 1'b0);
    add_word(32'sh7fff_ffff, 1'b0);
    add_word(0, 1'b0);
    add_word(0, 1'b0);
    add_word(-1, 1'b0);
    add_word(1, 1'b0);
    add_word(1, 1'b1);
    // one-word sequence
    add_word(5, 1'b1);
    // strictly falling
    add_word(32'sh7fff_ffff, 1'b0);
    add_word(100, 1'b0);
    add_word(0, 1'b0);
    add_word(32'sh8000_0000, 1'b1);
    // strictly rising, then a repeat of the top value
    add_word(-3, 1'b0);
    add_word(-2, 1'b0);
    add_word(-1, 1'b0);
    add_word(0, 1'b0);
    add_word(5, 1'b0);
    add_word(7, 1'b0);
    add_word(7, 1'b1);
    // next sequence must start from a cleared count, held until all is drained
    add_word(32'sh7fff_ffff, 1'b1, 1'b1);

    while (words_added < 200)
      add_random_sequence($urandom_range(19) == 0);
    wait_idle();

    send_idle_pct = 88;
    recv_idle_pct = 34;
    add_random_sequence(1'b1);
    while (words_added < 400)
      add_random_sequence($urandom_range(19) == 0);
    wait_idle();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_added < 580)
      add_random_sequence($urandom_range(19) == 0);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
